@@ hw/rtl/ffe_pkg.sv @@
// shared types, widths, register codes and rounding helper of the form factor core
package ffe_pkg;

    // field and register widths
    localparam int Q2_W          = 24;
    localparam int MASS_W        = 23;
    localparam int RHO_W         = 18;
    localparam int FF_W          = 24;
    localparam int CFG_ADDR_W    = 2;
    localparam int FRAC_BITS_DEF = 20;

    // internal datapath widths
    localparam int SQRT_PREC = 14;
    localparam int SQ_IN_W   = 62;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 33;
    localparam int DEN_W     = 32;
    localparam int QUO_W     = 31;
    localparam int Z_W       = 32;
    localparam int Z_FRAC    = 30;
    localparam int RHO_FRAC  = 16;
    localparam int P30_W     = 48;

    // register reset values
    localparam logic [MASS_W-1:0] PARENT_MASS_RST   = 23'd5535433;
    localparam logic [MASS_W-1:0] DAUGHTER_MASS_RST = 23'd1959788;
    localparam logic [RHO_W-1:0]  SLOPE_RHO2_RST    = 18'd76677;
    localparam logic [RHO_W-1:0]  V1_NORM_RST       = 18'd65536;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PARENT_MASS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DAUGHTER_MASS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOPE_RHO2    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_V1_NORM       = 2'd3;

    // output saturation limits
    localparam logic signed [63:0] FF_MAX = 64'sd8388607;
    localparam logic signed [63:0] FF_MIN = -64'sd8388608;

    // one lane of the square root pipeline
    typedef struct packed {
        logic [SQ_IN_W-1:0] x;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } t_sq_lane;

    // one lane of the divider pipeline; nq holds numerator bits then quotient
    typedef struct packed {
        logic [QUO_W-1:0] nq;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } t_div_lane;

    // sideband carried through the divider
    typedef struct packed {
        logic err;
        logic neg;
    } t_div_tag;

    // divide by 2^n, round to nearest, ties away from zero
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] x,
                                                     input int n);
        logic [63:0] mag;
        logic [63:0] m;
        mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
        m = (mag + (64'd1 << (n - 1))) >> n;
        return x[63] ? $signed(64'd0 - m) : $signed(m);
    endfunction

endpackage

@@ hw/rtl/ffe_sqrt_pipe.sv @@
// two-lane pipelined integer square root, one result bit per stage
module ffe_sqrt_pipe import ffe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_err,
    input  logic [SQ_IN_W-1:0] i_x_a,
    input  logic [SQ_IN_W-1:0] i_x_b,
    output logic               o_valid,
    output logic               o_err,
    output logic [ROOT_W-1:0]  o_root_a,
    output logic [ROOT_W-1:0]  o_root_b
);

    // one restoring step: bring down two bits, try root*4+1
    function automatic t_sq_lane sq_step(input t_sq_lane s);
        t_sq_lane    o;
        logic [REM_W+1:0] rem2;
        logic [REM_W+1:0] trial;
        rem2  = {s.rem, s.x[SQ_IN_W-1 -: 2]};
        trial = {{(REM_W+2-ROOT_W-2){1'b0}}, s.root, 2'b01};
        o.x   = {s.x[SQ_IN_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = REM_W'(rem2 - trial);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rem2[REM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    t_sq_lane r_a [ROOT_W];
    t_sq_lane r_b [ROOT_W];
    logic     r_v [ROOT_W];
    logic     r_e [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_stage
            t_sq_lane in_a;
            t_sq_lane in_b;
            logic     in_v;
            logic     in_e;
            if (g == 0) begin : g_first
                assign in_a = '{x: i_x_a, rem: '0, root: '0};
                assign in_b = '{x: i_x_b, rem: '0, root: '0};
                assign in_v = i_valid;
                assign in_e = i_err;
            end else begin : g_next
                assign in_a = r_a[g-1];
                assign in_b = r_b[g-1];
                assign in_v = r_v[g-1];
                assign in_e = r_e[g-1];
            end

            // step datapath
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a[g] <= sq_step(in_a);
                    r_b[g] <= sq_step(in_b);
                    r_e[g] <= in_e;
                end
            end

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= in_v;
                end
            end
        end
    endgenerate

    assign o_valid  = r_v[ROOT_W-1];
    assign o_err    = r_e[ROOT_W-1];
    assign o_root_a = r_a[ROOT_W-1].root;
    assign o_root_b = r_b[ROOT_W-1].root;

endmodule

@@ hw/rtl/ffe_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
module ffe_div_pipe import ffe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_div_tag              i_tag,
    input  logic [QUO_W+DEN_W-2:0] i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic                  o_valid,
    output t_div_tag              o_tag,
    output logic [QUO_W-1:0]      o_quo
);

    // one step: shift in a numerator bit, subtract when it fits
    function automatic t_div_lane div_step(input t_div_lane s);
        t_div_lane        o;
        logic [DEN_W:0]   rem2;
        logic             qb;
        rem2 = {s.rem, s.nq[QUO_W-1]};
        if (rem2 >= {1'b0, s.den}) begin
            o.rem = DEN_W'(rem2 - {1'b0, s.den});
            qb    = 1'b1;
        end else begin
            o.rem = rem2[DEN_W-1:0];
            qb    = 1'b0;
        end
        o.nq  = {s.nq[QUO_W-2:0], qb};
        o.den = s.den;
        return o;
    endfunction

    t_div_lane r_l [QUO_W];
    t_div_tag  r_t [QUO_W];
    logic      r_v [QUO_W];

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++) begin : g_stage
            t_div_lane in_l;
            t_div_tag  in_t;
            logic      in_v;
            if (g == 0) begin : g_first
                // upper numerator bits start as the partial remainder
                assign in_l = '{nq: i_num[QUO_W-1:0],
                                rem: {1'b0, i_num[QUO_W+DEN_W-2:QUO_W]},
                                den: i_den};
                assign in_t = i_tag;
                assign in_v = i_valid;
            end else begin : g_next
                assign in_l = r_l[g-1];
                assign in_t = r_t[g-1];
                assign in_v = r_v[g-1];
            end

            // step datapath
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_l[g] <= div_step(in_l);
                    r_t[g] <= in_t;
                end
            end

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= in_v;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QUO_W-1];
    assign o_tag   = r_t[QUO_W-1];
    assign o_quo   = r_l[QUO_W-1].nq;

endmodule

@@ hw/rtl/ffe_poly_pipe.sv @@
// pipelined cubic in z, normalization, rounding and saturation
module ffe_poly_pipe import ffe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_err,
    input  logic signed [Z_W-1:0] i_z,
    input  logic [RHO_W-1:0]      i_rho,
    input  logic [RHO_W-1:0]      i_v1,
    output logic                  o_valid,
    output logic                  o_err,
    output logic [FF_W-1:0]       o_ff
);

    localparam int NSTG = 8;
    localparam int OUT_SHIFT = Z_FRAC + RHO_FRAC - FRAC_BITS;

    // coefficients from the slope register
    logic signed [21:0] c1;
    logic signed [24:0] c2;
    logic signed [26:0] c3;
    assign c1 = $signed({1'b0, i_rho, 3'b000});
    assign c2 = $signed({7'b0, i_rho}) * 25'sd51 - 25'sd655360;
    assign c3 = $signed({9'b0, i_rho}) * 27'sd252 - 27'sd5505024;

    logic r_v [NSTG];
    logic r_e [NSTG];

    // stage 1: z squared and c1 z
    logic signed [Z_W-1:0] r1_z;
    logic signed [63:0]    r1_zz;
    logic signed [53:0]    r1_c1z;
    // stage 2: z2
    logic signed [Z_W-1:0] r2_z;
    logic signed [Z_W-1:0] r2_z2;
    logic signed [53:0]    r2_c1z;
    // stage 3: z2 z and c2 z2
    logic signed [63:0]    r3_z2z;
    logic signed [56:0]    r3_c2z2;
    logic signed [53:0]    r3_c1z;
    // stage 4: z3
    logic signed [Z_W-1:0] r4_z3;
    logic signed [56:0]    r4_c2z2;
    logic signed [53:0]    r4_c1z;
    // stage 5: c3 z3
    logic signed [58:0]    r5_c3z3;
    logic signed [56:0]    r5_c2z2;
    logic signed [53:0]    r5_c1z;
    // stage 6: p30
    logic signed [P30_W-1:0] r6_p30;
    // stage 7: scaled by v1
    logic signed [63:0]    r7_r;
    // stage 8: output
    logic [FF_W-1:0]       r8_ff;

    logic signed [63:0] n6_p;
    logic signed [63:0] n8_ff;
    assign n6_p = (64'sd1 <<< (Z_FRAC + RHO_FRAC)) - 64'(r5_c1z) + 64'(r5_c2z2)
                  - 64'(r5_c3z3);
    assign n8_ff = shr_round(r7_r, OUT_SHIFT);

    // arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_z    <= i_z;
            r1_zz   <= i_z * i_z;
            r1_c1z  <= c1 * i_z;
            r2_z    <= r1_z;
            r2_z2   <= Z_W'(shr_round(r1_zz, Z_FRAC));
            r2_c1z  <= r1_c1z;
            r3_z2z  <= r2_z2 * r2_z;
            r3_c2z2 <= c2 * r2_z2;
            r3_c1z  <= r2_c1z;
            r4_z3   <= Z_W'(shr_round(r3_z2z, Z_FRAC));
            r4_c2z2 <= r3_c2z2;
            r4_c1z  <= r3_c1z;
            r5_c3z3 <= c3 * r4_z3;
            r5_c2z2 <= r4_c2z2;
            r5_c1z  <= r4_c1z;
            r6_p30  <= P30_W'(shr_round(n6_p, RHO_FRAC));
            r7_r    <= $signed({1'b0, i_v1}) * r6_p30;
            if (r_e[NSTG-2]) begin
                r8_ff <= '0;
            end else if (n8_ff > FF_MAX) begin
                r8_ff <= FF_W'(FF_MAX);
            end else if (n8_ff < FF_MIN) begin
                r8_ff <= FF_W'(FF_MIN);
            end else begin
                r8_ff <= FF_W'(n8_ff);
            end
        end
    end

    // error sideband
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= i_err;
            for (int k = 1; k < NSTG; k++) begin
                r_e[k] <= r_e[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_err   = r_e[NSTG-1];
    assign o_ff    = r8_ff;

endmodule

@@ hw/rtl/semileptonic_form_factor_eval_core.sv @@
// top level of the dispersive b to d form factor core
// Usage:
//   s_axis carries one q2 value per transaction (unsigned, FRAC_BITS fraction
//   bits). m_axis returns one transaction per input: tdata holds the signed
//   form factor, tuser the range flag (set when w+1 is negative or a mass is
//   zero; the form factor is then zero).
//   Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata; the user
//   must write them only while no transaction is in flight; the block itself does not enforce this.
// Throughput: one transaction per cycle while the output is not held by the receiver.
// Pipeline: two setup stages, 31 square root stages (one root bit each),
//   one stage forming z numerator and denominator, 31 divider stages (one
//   quotient bit each) and eight stages for the cubic, scaling and saturation,
//   the last being the output register.
// Reset clears all valid bits and loads the register defaults.
// Stall: when the output is held by the receiver the whole pipeline freezes
//   and s_axis tready drops in the same cycle; nothing is lost or repeated.
module semileptonic_form_factor_eval_core import ffe_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [Q2_W-1:0]       i_s_axis_tdata,   // [23:0] q2_value
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [FF_W-1:0]       o_m_axis_tdata,   // [23:0] form_factor
    output logic                  o_m_axis_tuser,   // [0] range_error
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [MASS_W-1:0]     i_cfg_wdata
);

    localparam int TW = ((48 > Q2_W + FRAC_BITS) ? 48 : Q2_W + FRAC_BITS) + 1;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // configuration registers
    logic [MASS_W-1:0] r_mb;
    logic [MASS_W-1:0] r_md;
    logic [RHO_W-1:0]  r_rho;
    logic [RHO_W-1:0]  r_v1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mb  <= PARENT_MASS_RST;
            r_md  <= DAUGHTER_MASS_RST;
            r_rho <= SLOPE_RHO2_RST;
            r_v1  <= V1_NORM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PARENT_MASS:   r_mb  <= i_cfg_wdata;
                CFG_DAUGHTER_MASS: r_md  <= i_cfg_wdata;
                CFG_SLOPE_RHO2:    r_rho <= i_cfg_wdata[RHO_W-1:0];
                CFG_V1_NORM:       r_v1  <= i_cfg_wdata[RHO_W-1:0];
                default: ;
            endcase
        end
    end

    // stage a: mass products
    logic [MASS_W:0]   msum;
    logic              r_a_v;
    logic [47:0]       r_a_sq;
    logic [45:0]       r_a_prod;
    logic [Q2_W-1:0]   r_a_q2;
    assign msum = {1'b0, r_mb} + {1'b0, r_md};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sq   <= msum * msum;
            r_a_prod <= r_mb * r_md;
            r_a_q2   <= i_s_axis_tdata;
        end
    end

    // stage b: t, range check, root operands
    logic signed [TW-1:0] t_s;
    logic                 r_b_v;
    logic                 r_b_err;
    logic [SQ_IN_W-1:0]   r_b_xa;
    logic [SQ_IN_W-1:0]   r_b_xb;
    assign t_s = $signed({{(TW-48){1'b0}}, r_a_sq})
               - $signed({{(TW-Q2_W-FRAC_BITS){1'b0}}, r_a_q2, {FRAC_BITS{1'b0}}});
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_err <= t_s[TW-1] || (r_mb == '0) || (r_md == '0);
            r_b_xa  <= {t_s[47:0], {SQRT_PREC{1'b0}}};
            r_b_xb  <= {r_a_prod, 2'b00, {SQRT_PREC{1'b0}}};
        end
    end

    // front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_s_axis_tvalid;
            r_b_v <= r_a_v;
        end
    end

    // square roots of t and d
    logic              sq_v;
    logic              sq_err;
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;
    ffe_sqrt_pipe u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_b_v),
        .i_err    (r_b_err),
        .i_x_a    (r_b_xa),
        .i_x_b    (r_b_xb),
        .o_valid  (sq_v),
        .o_err    (sq_err),
        .o_root_a (root_a),
        .o_root_b (root_b)
    );

    // stage c: rounded numerator and denominator of z
    logic [ROOT_W-1:0]        diff;
    logic [DEN_W-1:0]         den;
    logic                     r_c_v;
    t_div_tag                 r_c_tag;
    logic [QUO_W+DEN_W-2:0]   r_c_num;
    logic [DEN_W-1:0]         r_c_den;
    assign diff = (root_a >= root_b) ? (root_a - root_b) : (root_b - root_a);
    assign den  = {1'b0, root_a} + {1'b0, root_b};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_tag <= '{err: sq_err, neg: (root_a < root_b)};
            r_c_num <= {1'b0, diff, {Z_FRAC{1'b0}}} + {{QUO_W{1'b0}}, den[DEN_W-1:1]};
            r_c_den <= den;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= sq_v;
        end
    end

    // divider
    logic             dv_v;
    t_div_tag         dv_tag;
    logic [QUO_W-1:0] dv_quo;
    ffe_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_v),
        .i_tag   (r_c_tag),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .o_valid (dv_v),
        .o_tag   (dv_tag),
        .o_quo   (dv_quo)
    );

    // signed z
    logic signed [Z_W-1:0] z;
    assign z = dv_tag.neg ? $signed(Z_W'(0) - {1'b0, dv_quo}) : $signed({1'b0, dv_quo});

    ffe_poly_pipe #(.FRAC_BITS(FRAC_BITS)) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_v),
        .i_err   (dv_tag.err),
        .i_z     (z),
        .i_rho   (r_rho),
        .i_v1    (r_v1),
        .o_valid (o_m_axis_tvalid),
        .o_err   (o_m_axis_tuser),
        .o_ff    (o_m_axis_tdata)
    );

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("range error with nonzero form factor");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v && (r_c_den != '0) |->
            {1'b0, r_c_num[QUO_W+DEN_W-2:QUO_W]} < r_c_den)
        else $error("divider quotient overflow");

endmodule
